FILE: sv/wabr_pkg.sv
// Package for the word-aligned byte realigner.
// Holds the field widths, register indexes and the structs shared by the
// interfaces, the merge datapath and the top level. No dependencies.
`default_nettype none

package wabr_pkg;

    localparam int WORD_W = 32;
    localparam int LANES  = 4;
    localparam int BE_W   = 4;
    localparam int OFF_W  = 2;
    localparam int BC_W   = 13;
    localparam int IDX_W  = 11;
    localparam int CIDX_W = 2;

    // result queue
    localparam int QDEPTH = 4;
    localparam int QA_W   = 2;
    localparam int QC_W   = 3;

    // byte mask of one lane
    localparam logic [7:0] LANE_MASK = 8'hff;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_SRC_OFF    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_DST_OFF    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_BYTE_COUNT = 2'd2;

    // one destination write
    typedef struct packed {
        logic [WORD_W-1:0] dest_word;
        logic [BE_W-1:0]   byte_enable;
        logic [IDX_W-1:0]  word_index;
        logic              last_write;
    } t_wr;

    // transfer settings, count already saturated
    typedef struct packed {
        logic [OFF_W-1:0] src_off;
        logic [OFF_W-1:0] dst_off;
        logic [BC_W-1:0]  count;
    } t_cfg;

    // realigner state carried between words
    typedef struct packed {
        logic              first;
        logic [WORD_W-1:0] partial;
        logic [OFF_W-1:0]  fill;
        logic [BE_W-1:0]   valid;
        logic [BC_W-1:0]   left;
        logic [IDX_W-1:0]  oidx;
    } t_state;

    // writes produced by one source word, packed in order
    typedef struct packed {
        logic [1:0] n;
        t_wr        w0;
        t_wr        w1;
    } t_emit;

endpackage

`default_nettype wire

FILE: sv/wabr_ifs.sv
// Valid/ready channel interfaces of the byte realigner.
// Source side carries one aligned source word, destination side one write.
// Depends on wabr_pkg.
`default_nettype none

interface wabr_src_if import wabr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] source_word;

    modport source (output valid, output source_word, input ready);
    modport sink   (input valid, input source_word, output ready);
endinterface

interface wabr_dst_if import wabr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] dest_word;
    logic [BE_W-1:0]   byte_enable;
    logic [IDX_W-1:0]  word_index;
    logic              last_write;

    modport source (output valid, output dest_word, output byte_enable,
                    output word_index, output last_write, input ready);
    modport sink   (input valid, input dest_word, input byte_enable,
                    input word_index, input last_write, output ready);
endinterface

`default_nettype wire

FILE: sv/word_aligned_byte_realigner_top.sv
// Top level of the word-aligned byte realigner.
// Instantiates wabr_merge; uses wabr_pkg and the channel interfaces.
//
// Usage:
//   Program source offset, destination offset and byte count through the
//   write port while the block is idle. Then feed aligned source words on
//   i_src, starting with the word that holds the first byte. Each word on
//   o_dst is one destination write with a byte-enable mask, a word index
//   counted from the first written word and a last flag on the final write.
//   After the last byte the block is ready for the next transfer, which
//   again samples the settings with its first source word.
// Timing:
//   One source word per cycle while i_src.ready is high. A write is queued
//   when the word that completes it is taken. Writes wait in a 4-entry result
//   queue; i_src.ready is high while the queue holds at most two writes,
//   since one word can produce two writes at the end of a transfer.
// Reset and stall:
//   Reset empties the queue, clears the settings to offsets 0 and count 1
//   and arms the start of a transfer. When the receiver stalls, writes stay
//   queued and the source side stops once the queue has no room for two.
`default_nettype none

module word_aligned_byte_realigner_top import wabr_pkg::*; #(
    parameter int MAX_BYTES = 4096
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    wabr_src_if.sink           i_src,
    wabr_dst_if.source         o_dst,
    input  wire                i_cfg_we,
    input  wire [CIDX_W-1:0]   i_cfg_idx,
    input  wire [BC_W-1:0]     i_cfg_data
);

    t_cfg               r_cfg;
    t_state             r_st;
    t_state             n_st;
    t_emit              emit;
    t_wr                r_q [QDEPTH];
    logic [QA_W-1:0]    r_wp;
    logic [QA_W-1:0]    r_rp;
    logic [QC_W-1:0]    r_cnt;
    logic               acc;
    logic               pop;
    logic [BC_W-1:0]    count_sat;
    logic [WORD_W-1:0]  be_bits;

    // configuration registers, count saturated on write
    assign count_sat = ({{(32-BC_W){1'b0}}, i_cfg_data} > 32'(MAX_BYTES))
                       ? BC_W'(MAX_BYTES) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_off <= '0;
            r_cfg.dst_off <= '0;
            r_cfg.count   <= BC_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SRC_OFF:    r_cfg.src_off <= i_cfg_data[OFF_W-1:0];
                CFG_DST_OFF:    r_cfg.dst_off <= i_cfg_data[OFF_W-1:0];
                CFG_BYTE_COUNT: r_cfg.count   <= count_sat;
                default: ;
            endcase
        end
    end

    // lane merge
    wabr_merge u_merge (
        .i_cfg  (r_cfg),
        .i_st   (r_st),
        .i_word (i_src.source_word),
        .o_st   (n_st),
        .o_emit (emit)
    );

    assign i_src.ready = (r_cnt <= QC_W'(QDEPTH - 2));
    assign acc         = i_src.valid && i_src.ready;
    assign pop         = o_dst.valid && o_dst.ready;

    // realigner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.first   <= 1'b1;
            r_st.partial <= '0;
            r_st.fill    <= '0;
            r_st.valid   <= '0;
            r_st.left    <= '0;
            r_st.oidx    <= '0;
        end else if (acc) begin
            r_st <= n_st;
        end
    end

    // result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (acc)
                r_wp <= r_wp + QA_W'(emit.n);
            if (pop)
                r_rp <= r_rp + QA_W'(1);
            r_cnt <= r_cnt + (acc ? QC_W'(emit.n) : QC_W'(0)) - QC_W'(pop);
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (acc && (emit.n != 2'd0))
            r_q[r_wp] <= emit.w0;
        if (acc && (emit.n == 2'd2))
            r_q[r_wp + QA_W'(1)] <= emit.w1;
    end

    assign o_dst.valid       = (r_cnt != '0);
    assign o_dst.dest_word   = r_q[r_rp].dest_word;
    assign o_dst.byte_enable = r_q[r_rp].byte_enable;
    assign o_dst.word_index  = r_q[r_rp].word_index;
    assign o_dst.last_write  = r_q[r_rp].last_write;

    // lanes of the head write as a bit mask
    always_comb begin
        for (int b = 0; b < LANES; b++)
            be_bits[b*8 +: 8] = o_dst.byte_enable[b] ? LANE_MASK : 8'h00;
    end

    // checks
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QC_W'(QDEPTH))
        else $error("result queue overflow");

    a_be_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dst.valid |-> (o_dst.byte_enable != '0))
        else $error("write with no lane enabled");

    a_lanes_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dst.valid |-> ((o_dst.dest_word & ~be_bits) == '0))
        else $error("data in a disabled lane");

    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_st.first && (r_cfg.count == '0))
        |=> (r_st.first && (r_cnt <= $past(r_cnt))))
        else $error("zero-length transfer produced a write");

endmodule

`default_nettype wire

FILE: sv/wabr_merge.sv
// Lane merge datapath: shifts the useful bytes of one source word into the
// pending destination word and forms up to two writes plus the next state.
// Depends on wabr_pkg.
`default_nettype none

module wabr_merge import wabr_pkg::*; (
    input  wire t_cfg    i_cfg,
    input  wire t_state  i_st,
    input  wire [WORD_W-1:0] i_word,
    output t_state       o_st,
    output t_emit        o_emit
);

    t_state             cur;
    logic [OFF_W-1:0]   lane;
    logic [2:0]         avail;
    logic [2:0]         k;
    logic [2:0]         f;
    logic [BC_W-1:0]    left_n;
    logic [WORD_W-1:0]  src_sel;
    logic [63:0]        shifted;
    logic [63:0]        comb_w;
    logic [7:0]         mask8;
    logic               done;
    logic               emit0;
    logic               emit1;
    t_wr                wr0;
    t_wr                wr1;
    logic [WORD_W-1:0]  rem;
    logic [BE_W-1:0]    rem_mask;
    logic [OFF_W-1:0]   rem_fill;
    logic [IDX_W-1:0]   idx1;

    // start of transfer loads the settings
    always_comb begin
        cur  = i_st;
        lane = '0;
        if (i_st.first) begin
            cur.partial = '0;
            cur.valid   = '0;
            cur.fill    = i_cfg.dst_off;
            cur.left    = i_cfg.count;
            cur.oidx    = '0;
            lane        = i_cfg.src_off;
        end
    end

    // bytes taken from this word and where they land
    always_comb begin
        avail  = 3'd4 - {1'b0, lane};
        k      = (cur.left < {{(BC_W-3){1'b0}}, avail}) ? cur.left[2:0] : avail;
        f      = {1'b0, cur.fill} + k;
        left_n = cur.left - {{(BC_W-3){1'b0}}, k};
        for (int b = 0; b < LANES; b++) begin
            if ((3'(b) >= {1'b0, lane}) && (3'(b) < ({1'b0, lane} + k)))
                src_sel[b*8 +: 8] = i_word[b*8 +: 8] & LANE_MASK;
            else
                src_sel[b*8 +: 8] = 8'h00;
        end
        shifted = ({32'b0, src_sel} >> {lane, 3'b000}) << {cur.fill, 3'b000};
        comb_w  = {32'b0, cur.partial} | shifted;
        mask8   = {4'b0, cur.valid} | (8'((9'd1 << k) - 9'd1) << cur.fill);
        done    = (left_n == '0);
    end

    // word filled to its top lane goes out, remainder stays pending or goes out as the last write
    always_comb begin
        emit0           = f[2] && (cur.left != '0);
        wr0.dest_word   = comb_w[31:0];
        wr0.byte_enable = mask8[3:0];
        wr0.word_index  = cur.oidx;
        wr0.last_write  = done && (f == 3'd4);
        if (f[2]) begin
            rem      = comb_w[63:32];
            rem_mask = mask8[7:4];
            idx1     = cur.oidx + 11'd1;
        end else begin
            rem      = comb_w[31:0];
            rem_mask = mask8[3:0];
            idx1     = cur.oidx;
        end
        rem_fill        = f[1:0];
        emit1           = done && (rem_fill != '0) && (cur.left != '0);
        wr1.dest_word   = rem;
        wr1.byte_enable = rem_mask;
        wr1.word_index  = idx1;
        wr1.last_write  = 1'b1;
    end

    // next state and packed writes
    always_comb begin
        o_st = cur;
        if (cur.left == '0) begin
            // zero count: nothing moved, next word starts over
            o_st.first = 1'b1;
        end else if (done) begin
            o_st.first = 1'b1;
            o_st.left  = '0;
        end else begin
            o_st.first   = 1'b0;
            o_st.partial = rem;
            o_st.valid   = rem_mask;
            o_st.fill    = rem_fill;
            o_st.left    = left_n;
            o_st.oidx    = idx1;
        end
        o_emit.n  = {1'b0, emit0} + {1'b0, emit1};
        o_emit.w0 = emit0 ? wr0 : wr1;
        o_emit.w1 = wr1;
    end

endmodule

`default_nettype wire
